// ===== rtl/spcc_pkg.sv =====
package spcc_pkg;

    localparam logic [5:0] PRIME_SUMP_MINUTES = 6'd3;
    localparam logic [5:0] PRIME_BOTH_MINUTES = 6'd2;
    localparam logic [5:0] MINUTE_MAX         = 6'd59;
    localparam logic [6:0] MINUTES_PER_HOUR   = 7'd60;

    localparam logic signed [11:0] VALID_LOW_LIMIT  = -12'sd250;
    localparam logic signed [11:0] VALID_HIGH_LIMIT = 12'sd1800;
    localparam logic signed [11:0] ERROR_READING    = 12'sd320;

    typedef enum logic [4:0] {
        PH_OFF        = 5'b00001,
        PH_PRIME_SUMP = 5'b00010,
        PH_PRIME_BOTH = 5'b00100,
        PH_ON         = 5'b01000,
        PH_DRAIN      = 5'b10000
    } pump_phase_t;

    typedef enum logic [2:0] {
        CM_IDLE = 3'b001,
        CM_HOT  = 3'b010,
        CM_COLD = 3'b100
    } climate_mode_t;

    localparam logic [2:0] PHASE_CODE_OFF        = 3'd0;
    localparam logic [2:0] PHASE_CODE_PRIME_SUMP = 3'd1;
    localparam logic [2:0] PHASE_CODE_PRIME_BOTH = 3'd2;
    localparam logic [2:0] PHASE_CODE_ON         = 3'd3;
    localparam logic [2:0] PHASE_CODE_DRAIN      = 3'd4;

    localparam logic [1:0] MODE_CODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_CODE_HOT  = 2'd1;
    localparam logic [1:0] MODE_CODE_COLD = 2'd2;

    typedef enum logic [3:0] {
        REG_START_DELTA       = 4'd0,
        REG_STOP_DELTA        = 4'd1,
        REG_PANEL_START_LIMIT = 4'd2,
        REG_HOT_ENTER         = 4'd3,
        REG_HOT_LEAVE         = 4'd4,
        REG_COLD_ENTER        = 4'd5,
        REG_COLD_LEAVE        = 4'd6,
        REG_DRAIN_MINUTES     = 4'd7
    } cfg_index_t;

    typedef struct packed {
        logic [10:0] start_delta;
        logic [10:0] stop_delta;
        logic [11:0] panel_start_limit;
        logic [11:0] hot_enter;
        logic [11:0] hot_leave;
        logic [11:0] cold_enter;
        logic [11:0] cold_leave;
        logic [5:0]  drain_minutes;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        start_delta:       11'd300,
        stop_delta:        11'd100,
        panel_start_limit: 12'd1000,
        hot_enter:         12'd760,
        hot_leave:         12'd740,
        cold_enter:        12'd380,
        cold_leave:        12'd400,
        drain_minutes:     6'd5
    };

    typedef struct packed {
        logic [11:0] panel_temp;
        logic        panel_present;
        logic [11:0] pool_temp;
        logic        pool_present;
        logic [11:0] ambient_temp;
        logic        ambient_valid;
        logic        time_set;
        logic [5:0]  minute_now;
    } item_t;

    typedef struct packed {
        pump_phase_t phase;
        logic [5:0]  start_minute;
    } pump_ctx_t;

    function automatic logic [2:0] phase_code(input pump_phase_t phase);
        logic [2:0] code;
        unique case (phase)
            PH_PRIME_SUMP: code = PHASE_CODE_PRIME_SUMP;
            PH_PRIME_BOTH: code = PHASE_CODE_PRIME_BOTH;
            PH_ON:         code = PHASE_CODE_ON;
            PH_DRAIN:      code = PHASE_CODE_DRAIN;
            default:       code = PHASE_CODE_OFF;
        endcase
        return code;
    endfunction

    function automatic logic [1:0] mode_code(input climate_mode_t mode);
        logic [1:0] code;
        unique case (mode)
            CM_HOT:  code = MODE_CODE_HOT;
            CM_COLD: code = MODE_CODE_COLD;
            default: code = MODE_CODE_IDLE;
        endcase
        return code;
    endfunction

endpackage

// ===== rtl/spcc_reading_check.sv =====
module spcc_reading_check (
    input  logic signed [11:0] temp,
    input  logic               present,
    output logic               ok
);

    assign ok = present
              && !(temp < spcc_pkg::VALID_LOW_LIMIT)
              && !(temp > spcc_pkg::VALID_HIGH_LIMIT)
              && (temp != spcc_pkg::ERROR_READING);

endmodule

// ===== rtl/spcc_pump.sv =====
module spcc_pump (
    input  spcc_pkg::cfg_t      cfg,
    input  spcc_pkg::item_t     item,
    input  spcc_pkg::pump_ctx_t state,
    output spcc_pkg::pump_ctx_t state_next
);

    logic              panel_ok;
    logic              pool_ok;
    logic [5:0]        minute_c;
    logic [6:0]        diff;
    logic [6:0]        diff_wrap;
    logic [5:0]        elapsed;
    logic signed [13:0] panel_ext;
    logic signed [13:0] pool_plus_start;
    logic signed [13:0] pool_plus_stop;
    logic              start_cond;
    logic              keep_on;

    spcc_reading_check u_panel_check (
        .temp    ($signed(item.panel_temp)),
        .present (item.panel_present),
        .ok      (panel_ok)
    );

    spcc_reading_check u_pool_check (
        .temp    ($signed(item.pool_temp)),
        .present (item.pool_present),
        .ok      (pool_ok)
    );

    // minutes 60..63 count as 59
    assign minute_c  = (item.minute_now > spcc_pkg::MINUTE_MAX) ? spcc_pkg::MINUTE_MAX
                                                                : item.minute_now;
    assign diff      = {1'b0, minute_c} - {1'b0, state.start_minute};
    assign diff_wrap = diff + spcc_pkg::MINUTES_PER_HOUR;
    assign elapsed   = diff[6] ? diff_wrap[5:0] : diff[5:0];

    assign panel_ext       = $signed({{2{item.panel_temp[11]}}, item.panel_temp});
    assign pool_plus_start = $signed({{2{item.pool_temp[11]}}, item.pool_temp})
                           + $signed({3'b000, cfg.start_delta});
    assign pool_plus_stop  = $signed({{2{item.pool_temp[11]}}, item.pool_temp})
                           + $signed({3'b000, cfg.stop_delta});

    assign start_cond = item.time_set
                      && ((panel_ok && pool_ok && (panel_ext > pool_plus_start))
                          || (panel_ok && ($signed(item.panel_temp)
                                           > $signed(cfg.panel_start_limit))));
    assign keep_on    = panel_ok && pool_ok && (panel_ext > pool_plus_stop);

    always_comb
    begin
        state_next = state;
        unique case (state.phase)
            spcc_pkg::PH_PRIME_SUMP:
            begin
                if (!item.time_set)
                begin
                    state_next.phase = spcc_pkg::PH_OFF;
                end
                else if (elapsed > spcc_pkg::PRIME_SUMP_MINUTES)
                begin
                    state_next.phase        = spcc_pkg::PH_PRIME_BOTH;
                    state_next.start_minute = minute_c;
                end
            end
            spcc_pkg::PH_PRIME_BOTH:
            begin
                if (!item.time_set)
                begin
                    state_next.phase = spcc_pkg::PH_OFF;
                end
                else if (elapsed > spcc_pkg::PRIME_BOTH_MINUTES)
                begin
                    state_next.phase        = spcc_pkg::PH_ON;
                    state_next.start_minute = minute_c;
                end
            end
            // clock flag is not looked at while running
            spcc_pkg::PH_ON:
            begin
                if (!keep_on)
                begin
                    state_next.phase        = spcc_pkg::PH_DRAIN;
                    state_next.start_minute = minute_c;
                end
            end
            spcc_pkg::PH_DRAIN:
            begin
                if (!item.time_set || (elapsed > cfg.drain_minutes))
                begin
                    state_next.phase = spcc_pkg::PH_OFF;
                end
            end
            default:
            begin
                state_next.phase = spcc_pkg::PH_OFF;
                if (start_cond)
                begin
                    state_next.phase        = spcc_pkg::PH_PRIME_SUMP;
                    state_next.start_minute = minute_c;
                end
            end
        endcase
    end

endmodule

// ===== rtl/spcc_climate.sv =====
module spcc_climate (
    input  spcc_pkg::cfg_t          cfg,
    input  spcc_pkg::item_t         item,
    input  spcc_pkg::climate_mode_t mode,
    output spcc_pkg::climate_mode_t mode_next
);

    logic signed [11:0] amb;

    assign amb = $signed(item.ambient_temp);

    always_comb
    begin
        mode_next = mode;
        unique case (mode)
            spcc_pkg::CM_HOT:
            begin
                if (!item.ambient_valid || (amb < $signed(cfg.hot_leave)))
                begin
                    mode_next = spcc_pkg::CM_IDLE;
                end
            end
            spcc_pkg::CM_COLD:
            begin
                if (!item.ambient_valid || (amb > $signed(cfg.cold_leave)))
                begin
                    mode_next = spcc_pkg::CM_IDLE;
                end
            end
            default:
            begin
                priority if (item.ambient_valid && (amb > $signed(cfg.hot_enter)))
                begin
                    mode_next = spcc_pkg::CM_HOT;
                end
                else if (item.ambient_valid && (amb < $signed(cfg.cold_enter)))
                begin
                    mode_next = spcc_pkg::CM_COLD;
                end
                else
                begin
                    mode_next = spcc_pkg::CM_IDLE;
                end
            end
        endcase
    end

endmodule

// ===== rtl/solar_pump_and_climate_controller_core.sv =====
// solar pool pump sequencer and greenhouse climate controller
//
// item channel (item_valid / item_ready) takes one control tick: panel, pool
// and ambient temperatures in tenths of a degree F with their flags, the
// clock-synchronized flag and the minute of the hour. result channel
// (result_valid / result_ready) returns one item per tick: pump and climate
// drives plus the phase and mode codes after that tick's update.
// cfg channel (cfg_valid / cfg_ready, always ready) writes one threshold
// register per item by index; unknown indexes are dropped. write it only
// while no tick is in flight.
// a tick is registered on entry, evaluated by compare logic and registered
// again, together with the phase, mode and start-minute registers; one tick
// is accepted every cycle while result_ready does not hold the output.
// if result_ready stays low the result holds and one more tick is buffered in
// the entry register; after that item_ready drops.
// reset puts the pump in off, climate in idle, start minute at 0 and all
// thresholds at their defaults; both channels come up empty.
module solar_pump_and_climate_controller_core (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        item_valid,
    output logic        item_ready,
    input  logic [11:0] panel_temp,
    input  logic        panel_present,
    input  logic [11:0] pool_temp,
    input  logic        pool_present,
    input  logic [11:0] ambient_temp,
    input  logic        ambient_valid,
    input  logic        time_set,
    input  logic [5:0]  minute_now,

    output logic        result_valid,
    input  logic        result_ready,
    output logic        sump_pump_on,
    output logic        circ_pump_on,
    output logic        fan_on,
    output logic        dehumidifier_on,
    output logic [2:0]  pump_phase,
    output logic [1:0]  climate_mode,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_index,
    input  logic [11:0] cfg_data
);

    spcc_pkg::cfg_t          cfg_reg;
    spcc_pkg::cfg_t          cfg_next;
    spcc_pkg::item_t         stage_item_reg;
    spcc_pkg::item_t         stage_item_next;
    logic                    stage_valid_reg;
    logic                    stage_valid_next;
    spcc_pkg::pump_ctx_t     pump_reg;
    spcc_pkg::pump_ctx_t     pump_next;
    spcc_pkg::pump_ctx_t     pump_calc;
    spcc_pkg::climate_mode_t climate_mode_reg;
    spcc_pkg::climate_mode_t climate_mode_next;
    spcc_pkg::climate_mode_t climate_calc;
    logic                    result_valid_reg;
    logic                    result_valid_next;
    logic                    sump_reg;
    logic                    sump_next;
    logic                    circ_reg;
    logic                    circ_next;
    logic                    fan_reg;
    logic                    fan_next;
    logic                    dehum_reg;
    logic                    dehum_next;
    logic [2:0]              phase_out_reg;
    logic [2:0]              phase_out_next;
    logic [1:0]              mode_out_reg;
    logic [1:0]              mode_out_next;
    logic                    item_accept;
    logic                    advance;

    assign cfg_ready   = 1'b1;
    assign advance     = stage_valid_reg && (!result_valid_reg || result_ready);
    assign item_ready  = !stage_valid_reg || advance;
    assign item_accept = item_valid && item_ready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                spcc_pkg::REG_START_DELTA:       cfg_next.start_delta       = cfg_data[10:0];
                spcc_pkg::REG_STOP_DELTA:        cfg_next.stop_delta        = cfg_data[10:0];
                spcc_pkg::REG_PANEL_START_LIMIT: cfg_next.panel_start_limit = cfg_data;
                spcc_pkg::REG_HOT_ENTER:         cfg_next.hot_enter         = cfg_data;
                spcc_pkg::REG_HOT_LEAVE:         cfg_next.hot_leave         = cfg_data;
                spcc_pkg::REG_COLD_ENTER:        cfg_next.cold_enter        = cfg_data;
                spcc_pkg::REG_COLD_LEAVE:        cfg_next.cold_leave        = cfg_data;
                spcc_pkg::REG_DRAIN_MINUTES:     cfg_next.drain_minutes     = cfg_data[5:0];
                default:                         cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        stage_item_next = item_accept ? '{
            panel_temp:    panel_temp,
            panel_present: panel_present,
            pool_temp:     pool_temp,
            pool_present:  pool_present,
            ambient_temp:  ambient_temp,
            ambient_valid: ambient_valid,
            time_set:      time_set,
            minute_now:    minute_now
        } : stage_item_reg;
        stage_valid_next = item_accept ? 1'b1 : (advance ? 1'b0 : stage_valid_reg);
    end

    spcc_pump u_pump (
        .cfg        (cfg_reg),
        .item       (stage_item_reg),
        .state      (pump_reg),
        .state_next (pump_calc)
    );

    spcc_climate u_climate (
        .cfg       (cfg_reg),
        .item      (stage_item_reg),
        .mode      (climate_mode_reg),
        .mode_next (climate_calc)
    );

    always_comb
    begin
        pump_next         = advance ? pump_calc : pump_reg;
        climate_mode_next = advance ? climate_calc : climate_mode_reg;
        result_valid_next = advance ? 1'b1 : (result_ready ? 1'b0 : result_valid_reg);
        sump_next         = sump_reg;
        circ_next         = circ_reg;
        fan_next          = fan_reg;
        dehum_next        = dehum_reg;
        phase_out_next    = phase_out_reg;
        mode_out_next     = mode_out_reg;
        if (advance)
        begin
            sump_next      = (pump_calc.phase == spcc_pkg::PH_PRIME_SUMP)
                          || (pump_calc.phase == spcc_pkg::PH_PRIME_BOTH);
            circ_next      = (pump_calc.phase == spcc_pkg::PH_PRIME_BOTH)
                          || (pump_calc.phase == spcc_pkg::PH_ON);
            fan_next       = (climate_calc == spcc_pkg::CM_HOT);
            dehum_next     = (climate_calc == spcc_pkg::CM_COLD);
            phase_out_next = spcc_pkg::phase_code(pump_calc.phase);
            mode_out_next  = spcc_pkg::mode_code(climate_calc);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg               <= spcc_pkg::CFG_RESET;
            stage_valid_reg       <= 1'b0;
            pump_reg.phase        <= spcc_pkg::PH_OFF;
            pump_reg.start_minute <= 6'd0;
            climate_mode_reg      <= spcc_pkg::CM_IDLE;
            result_valid_reg      <= 1'b0;
        end
        else
        begin
            cfg_reg          <= cfg_next;
            stage_valid_reg  <= stage_valid_next;
            pump_reg         <= pump_next;
            climate_mode_reg <= climate_mode_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stage_item_reg <= stage_item_next;
        sump_reg       <= sump_next;
        circ_reg       <= circ_next;
        fan_reg        <= fan_next;
        dehum_reg      <= dehum_next;
        phase_out_reg  <= phase_out_next;
        mode_out_reg   <= mode_out_next;
    end

    assign result_valid    = result_valid_reg;
    assign sump_pump_on    = sump_reg;
    assign circ_pump_on    = circ_reg;
    assign fan_on          = fan_reg;
    assign dehumidifier_on = dehum_reg;
    assign pump_phase      = phase_out_reg;
    assign climate_mode    = mode_out_reg;

    a_pump_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(pump_reg.phase))
        else $error("pump phase register lost its one-hot code");

    a_start_minute_range: assert property (@(posedge clk) disable iff (!rst_n)
        pump_reg.start_minute <= spcc_pkg::MINUTE_MAX)
        else $error("phase start minute out of range");

    a_off_exit: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (pump_reg.phase == spcc_pkg::PH_OFF) |=>
            (pump_reg.phase == spcc_pkg::PH_OFF)
            || (pump_reg.phase == spcc_pkg::PH_PRIME_SUMP))
        else $error("pump left off other than into prime sump");

    a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(pump_reg) && $stable(climate_mode_reg))
        else $error("controller state changed without a tick");

    a_drive_match: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> (sump_reg == ((phase_out_reg == spcc_pkg::PHASE_CODE_PRIME_SUMP)
                                        || (phase_out_reg == spcc_pkg::PHASE_CODE_PRIME_BOTH)))
                          && (fan_reg == (mode_out_reg == spcc_pkg::MODE_CODE_HOT)))
        else $error("drive outputs disagree with phase or mode code");

endmodule

// ===== sim/solar_pump_and_climate_controller_core_test.sv =====
module solar_pump_and_climate_controller_core_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT = 4000;
    localparam int READING_EDGES [9] = '{-2048, -251, -250, 319, 320, 321, 1800, 1801, 2047};

    typedef struct packed {
        logic       sump;
        logic       circ;
        logic       fan;
        logic       dehum;
        logic [2:0] phase;
        logic [1:0] mode;
    } drives_t;

    typedef struct {
        spcc_pkg::item_t tick;
        bit              hold;
    } tick_req_t;

    typedef struct {
        logic [3:0]  index;
        logic [11:0] data;
    } reg_write_t;

    logic clk;
    logic rst_n = 1'b0;

    logic        item_valid    = 1'b0;
    logic        item_ready;
    logic [11:0] panel_temp    = '0;
    logic        panel_present = 1'b0;
    logic [11:0] pool_temp     = '0;
    logic        pool_present  = 1'b0;
    logic [11:0] ambient_temp  = '0;
    logic        ambient_valid = 1'b0;
    logic        time_set      = 1'b0;
    logic [5:0]  minute_now    = '0;

    logic        result_valid;
    logic        result_ready  = 1'b0;
    logic        sump_pump_on;
    logic        circ_pump_on;
    logic        fan_on;
    logic        dehumidifier_on;
    logic [2:0]  pump_phase;
    logic [1:0]  climate_mode;

    logic        cfg_valid     = 1'b0;
    logic        cfg_ready;
    logic [3:0]  cfg_index     = '0;
    logic [11:0] cfg_data      = '0;

    tick_req_t  ticks_to_send[$];
    reg_write_t writes_to_send[$];
    drives_t    expected_drives[$];

    // controller model state
    logic [2:0]     phase_now;
    logic [1:0]     mode_now;
    logic [5:0]     phase_minute;
    spcc_pkg::cfg_t setting_model;

    spcc_pkg::cfg_t plan;
    int   sim_minute;
    bit   sunny;
    bit   no_idle = 1'b0;
    int   outstanding = 0;
    int   mismatches = 0;
    int   quiet_cycles = 0;

    solar_pump_and_climate_controller_core dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_valid      (item_valid),
        .item_ready      (item_ready),
        .panel_temp      (panel_temp),
        .panel_present   (panel_present),
        .pool_temp       (pool_temp),
        .pool_present    (pool_present),
        .ambient_temp    (ambient_temp),
        .ambient_valid   (ambient_valid),
        .time_set        (time_set),
        .minute_now      (minute_now),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .sump_pump_on    (sump_pump_on),
        .circ_pump_on    (circ_pump_on),
        .fan_on          (fan_on),
        .dehumidifier_on (dehumidifier_on),
        .pump_phase      (pump_phase),
        .climate_mode    (climate_mode),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic int fit12(input int v);
        if (v < -2048)
            return -2048;
        if (v > 2047)
            return 2047;
        return v;
    endfunction

    function automatic bit reading_ok(input int t, input logic present);
        return present && t >= int'(spcc_pkg::VALID_LOW_LIMIT)
            && t <= int'(spcc_pkg::VALID_HIGH_LIMIT)
            && t != int'(spcc_pkg::ERROR_READING);
    endfunction

    task automatic apply_setting(input logic [3:0] idx, input logic [11:0] data);
        case (idx)
            spcc_pkg::REG_START_DELTA:       setting_model.start_delta = data[10:0];
            spcc_pkg::REG_STOP_DELTA:        setting_model.stop_delta = data[10:0];
            spcc_pkg::REG_PANEL_START_LIMIT: setting_model.panel_start_limit = data;
            spcc_pkg::REG_HOT_ENTER:         setting_model.hot_enter = data;
            spcc_pkg::REG_HOT_LEAVE:         setting_model.hot_leave = data;
            spcc_pkg::REG_COLD_ENTER:        setting_model.cold_enter = data;
            spcc_pkg::REG_COLD_LEAVE:        setting_model.cold_leave = data;
            spcc_pkg::REG_DRAIN_MINUTES:     setting_model.drain_minutes = data[5:0];
            default: ;
        endcase
    endtask

    task automatic advance_controller(input spcc_pkg::item_t t, output drives_t d);
        int         panel;
        int         pool;
        int         amb;
        int         elapsed;
        logic [5:0] minute;
        bit         panel_ok;
        bit         pool_ok;
        bit         both_ok;
        panel = int'($signed(t.panel_temp));
        pool = int'($signed(t.pool_temp));
        amb = int'($signed(t.ambient_temp));
        panel_ok = reading_ok(panel, t.panel_present);
        pool_ok = reading_ok(pool, t.pool_present);
        both_ok = panel_ok && pool_ok;
        minute = (t.minute_now > spcc_pkg::MINUTE_MAX) ? spcc_pkg::MINUTE_MAX : t.minute_now;
        elapsed = (int'(minute) + 60 - int'(phase_minute)) % 60;

        case (phase_now)
            spcc_pkg::PHASE_CODE_PRIME_SUMP:
                if (!t.time_set)
                    phase_now = spcc_pkg::PHASE_CODE_OFF;
                else if (elapsed > int'(spcc_pkg::PRIME_SUMP_MINUTES))
                begin
                    phase_minute = minute;
                    phase_now = spcc_pkg::PHASE_CODE_PRIME_BOTH;
                end
            spcc_pkg::PHASE_CODE_PRIME_BOTH:
                if (!t.time_set)
                    phase_now = spcc_pkg::PHASE_CODE_OFF;
                else if (elapsed > int'(spcc_pkg::PRIME_BOTH_MINUTES))
                begin
                    phase_minute = minute;
                    phase_now = spcc_pkg::PHASE_CODE_ON;
                end
            spcc_pkg::PHASE_CODE_ON:
                // clock flag is ignored while running
                if (!(both_ok && panel > pool + int'(setting_model.stop_delta)))
                begin
                    phase_minute = minute;
                    phase_now = spcc_pkg::PHASE_CODE_DRAIN;
                end
            spcc_pkg::PHASE_CODE_DRAIN:
                if (!t.time_set || elapsed > int'(setting_model.drain_minutes))
                    phase_now = spcc_pkg::PHASE_CODE_OFF;
            default:
            begin
                phase_now = spcc_pkg::PHASE_CODE_OFF;
                if (t.time_set &&
                    ((both_ok && panel > pool + int'(setting_model.start_delta)) ||
                     (panel_ok && panel > int'($signed(setting_model.panel_start_limit)))))
                begin
                    phase_minute = minute;
                    phase_now = spcc_pkg::PHASE_CODE_PRIME_SUMP;
                end
            end
        endcase

        case (mode_now)
            spcc_pkg::MODE_CODE_HOT:
                if (!t.ambient_valid || amb < int'($signed(setting_model.hot_leave)))
                    mode_now = spcc_pkg::MODE_CODE_IDLE;
            spcc_pkg::MODE_CODE_COLD:
                if (!t.ambient_valid || amb > int'($signed(setting_model.cold_leave)))
                    mode_now = spcc_pkg::MODE_CODE_IDLE;
            default:
            begin
                mode_now = spcc_pkg::MODE_CODE_IDLE;
                if (t.ambient_valid && amb > int'($signed(setting_model.hot_enter)))
                    mode_now = spcc_pkg::MODE_CODE_HOT;
                else if (t.ambient_valid && amb < int'($signed(setting_model.cold_enter)))
                    mode_now = spcc_pkg::MODE_CODE_COLD;
            end
        endcase

        d.sump = (phase_now == spcc_pkg::PHASE_CODE_PRIME_SUMP)
              || (phase_now == spcc_pkg::PHASE_CODE_PRIME_BOTH);
        d.circ = (phase_now == spcc_pkg::PHASE_CODE_PRIME_BOTH)
              || (phase_now == spcc_pkg::PHASE_CODE_ON);
        d.fan = (mode_now == spcc_pkg::MODE_CODE_HOT);
        d.dehum = (mode_now == spcc_pkg::MODE_CODE_COLD);
        d.phase = phase_now;
        d.mode = mode_now;
    endtask

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // input side: tick channel and register write channel
    always @(posedge clk or negedge rst_n)
    begin : drive_inputs
        tick_req_t  req;
        reg_write_t w;
        int         send_gap;
        int         send_calm;
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            cfg_valid <= 1'b0;
            send_gap = 0;
            send_calm = 0;
        end
        else
        begin
            if (!item_valid || item_ready)
            begin
                if (send_calm > 0)
                    send_calm--;
                else if (!no_idle && $urandom_range(0, 79) == 0)
                    send_calm = $urandom_range(20, 100);
                if (send_gap > 0)
                begin
                    send_gap--;
                    item_valid <= 1'b0;
                end
                else if (!no_idle && send_calm == 0 && $urandom_range(0, 6) == 0)
                begin
                    send_gap = $urandom_range(1, 19) - 1;
                    item_valid <= 1'b0;
                end
                // a held item waits until every earlier result is back
                else if (ticks_to_send.size() > 0 &&
                         (!ticks_to_send[0].hold || (outstanding == 0 && !item_valid)))
                begin
                    req = ticks_to_send.pop_front();
                    {panel_temp, panel_present, pool_temp, pool_present, ambient_temp,
                     ambient_valid, time_set, minute_now} <= req.tick;
                    item_valid <= 1'b1;
                end
                else
                    item_valid <= 1'b0;
            end

            if (!cfg_valid || cfg_ready)
            begin
                if (writes_to_send.size() > 0)
                begin
                    w = writes_to_send.pop_front();
                    cfg_index <= w.index;
                    cfg_data <= w.data;
                    cfg_valid <= 1'b1;
                end
                else
                    cfg_valid <= 1'b0;
            end
        end
    end

    // output side: predicts on each accepted tick and checks each result item
    always @(posedge clk or negedge rst_n)
    begin : watch_outputs
        spcc_pkg::item_t seen;
        drives_t         want;
        drives_t         got;
        int              taken_in;
        int              taken_out;
        int              stall_left;
        int              recv_calm;
        if (!rst_n)
        begin
            phase_now = spcc_pkg::PHASE_CODE_OFF;
            mode_now = spcc_pkg::MODE_CODE_IDLE;
            phase_minute = '0;
            setting_model = spcc_pkg::CFG_RESET;
            stall_left = 0;
            recv_calm = 0;
            outstanding <= 0;
            result_ready <= 1'b0;
        end
        else
        begin
            taken_in = 0;
            taken_out = 0;
            if (cfg_valid && cfg_ready)
                apply_setting(cfg_index, cfg_data);

            if (item_valid && item_ready)
            begin
                seen = {panel_temp, panel_present, pool_temp, pool_present, ambient_temp,
                        ambient_valid, time_set, minute_now};
                advance_controller(seen, want);
                expected_drives.push_back(want);
                taken_in = 1;
            end

            if (result_valid && result_ready)
            begin
                taken_out = 1;
                got = {sump_pump_on, circ_pump_on, fan_on, dehumidifier_on,
                       pump_phase, climate_mode};
                if (expected_drives.size() == 0)
                begin
                    $error("result item arrived with no tick waiting for it");
                    mismatches++;
                end
                else
                begin
                    want = expected_drives.pop_front();
                    compare_field("sump_pump_on", want.sump, got.sump);
                    compare_field("circ_pump_on", want.circ, got.circ);
                    compare_field("fan_on", want.fan, got.fan);
                    compare_field("dehumidifier_on", want.dehum, got.dehum);
                    compare_field("pump_phase", want.phase, got.phase);
                    compare_field("climate_mode", want.mode, got.mode);
                end
            end
            outstanding <= outstanding + taken_in - taken_out;

            if (no_idle)
                result_ready <= 1'b1;
            else if (stall_left > 0)
            begin
                stall_left--;
                result_ready <= 1'b0;
            end
            else if (recv_calm > 0)
            begin
                recv_calm--;
                result_ready <= 1'b1;
            end
            else if ($urandom_range(0, 59) == 0)
            begin
                recv_calm = $urandom_range(20, 100);
                result_ready <= 1'b1;
            end
            else if ($urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 19) - 1;
                result_ready <= 1'b0;
            end
            else
                result_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : watchdog
        if (!rst_n || (item_valid && item_ready) || (result_valid && result_ready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    task automatic push_tick(input int panel, input bit pp, input int pool, input bit plp,
                             input int amb, input bit av, input bit ts, input int minute,
                             input bit hold = 1'b0);
        tick_req_t req;
        req.tick.panel_temp = 12'(panel);
        req.tick.panel_present = pp;
        req.tick.pool_temp = 12'(pool);
        req.tick.pool_present = plp;
        req.tick.ambient_temp = 12'(amb);
        req.tick.ambient_valid = av;
        req.tick.time_set = ts;
        req.tick.minute_now = 6'(minute);
        req.hold = hold;
        ticks_to_send.push_back(req);
    endtask

    task automatic push_random_tick();
        int panel;
        int pool;
        int amb;
        int minute;
        if ($urandom_range(0, 6) == 0)
        begin
            // noise: every field over its full width
            push_tick(int'($urandom_range(0, 4095)) - 2048, 1'($urandom),
                      int'($urandom_range(0, 4095)) - 2048, 1'($urandom),
                      int'($urandom_range(0, 4095)) - 2048, 1'($urandom),
                      1'($urandom), $urandom_range(0, 63), $urandom_range(0, 99) == 0);
            return;
        end

        if ($urandom_range(0, 49) == 0)
            sim_minute = $urandom_range(0, 59);
        else
            sim_minute = (sim_minute + $urandom_range(0, 3)) % 60;
        if ($urandom_range(0, 29) == 0)
            sunny = !sunny;
        minute = ($urandom_range(0, 49) == 0) ? $urandom_range(60, 63) : sim_minute;

        pool = int'($urandom_range(0, 1200)) - 100;
        if (sunny)
            panel = pool + int'(plan.start_delta) + int'($urandom_range(0, 300));
        else
            panel = pool + int'(plan.stop_delta) + int'($urandom_range(0, 40)) - 20;
        if ($urandom_range(0, 11) == 0)
            panel = READING_EDGES[$urandom_range(0, 8)];
        if ($urandom_range(0, 11) == 0)
            pool = READING_EDGES[$urandom_range(0, 8)];

        case ($urandom_range(0, 3))
            0: amb = int'($signed(plan.hot_enter));
            1: amb = int'($signed(plan.hot_leave));
            2: amb = int'($signed(plan.cold_enter));
            default: amb = int'($signed(plan.cold_leave));
        endcase
        if ($urandom_range(0, 3) == 0)
            amb += int'($urandom_range(0, 160)) - 80;
        else
            amb += int'($urandom_range(0, 8)) - 4;

        push_tick(fit12(panel), $urandom_range(0, 19) != 0, fit12(pool),
                  $urandom_range(0, 19) != 0, fit12(amb), $urandom_range(0, 24) != 0,
                  $urandom_range(0, 39) != 0, minute, $urandom_range(0, 149) == 0);
    endtask

    task automatic wait_until_idle();
        do
            @(negedge clk);
        while (ticks_to_send.size() != 0 || item_valid || outstanding != 0 ||
               writes_to_send.size() != 0 || cfg_valid);
        repeat (3) @(negedge clk);
    endtask

    task automatic run_random(input int count);
        repeat (count) push_random_tick();
        wait_until_idle();
    endtask

    task automatic program_setting(input spcc_pkg::cfg_t s);
        plan = s;
        writes_to_send.push_back('{spcc_pkg::REG_START_DELTA, {1'($urandom), s.start_delta}});
        writes_to_send.push_back('{spcc_pkg::REG_STOP_DELTA, {1'($urandom), s.stop_delta}});
        writes_to_send.push_back('{spcc_pkg::REG_PANEL_START_LIMIT, s.panel_start_limit});
        writes_to_send.push_back('{spcc_pkg::REG_HOT_ENTER, s.hot_enter});
        writes_to_send.push_back('{spcc_pkg::REG_HOT_LEAVE, s.hot_leave});
        writes_to_send.push_back('{spcc_pkg::REG_COLD_ENTER, s.cold_enter});
        writes_to_send.push_back('{spcc_pkg::REG_COLD_LEAVE, s.cold_leave});
        writes_to_send.push_back('{spcc_pkg::REG_DRAIN_MINUTES,
                                   {6'($urandom), s.drain_minutes}});
        // index past the register list must be dropped
        writes_to_send.push_back('{4'($urandom_range(8, 15)), 12'($urandom)});
        wait_until_idle();
    endtask

    function automatic spcc_pkg::cfg_t random_setting();
        spcc_pkg::cfg_t s;
        int             hot;
        int             cold;
        hot = $urandom_range(600, 900);
        cold = $urandom_range(200, 500);
        s.start_delta = 11'($urandom_range(0, 800));
        s.stop_delta = 11'($urandom_range(0, s.start_delta));
        s.panel_start_limit = 12'($urandom_range(400, 1700));
        s.hot_enter = 12'(hot);
        s.hot_leave = 12'(hot - int'($urandom_range(0, 60)));
        s.cold_enter = 12'(cold);
        s.cold_leave = 12'(cold + int'($urandom_range(0, 60)));
        s.drain_minutes = 6'($urandom_range(0, 63));
        return s;
    endfunction

    initial
    begin : stimulus
        spcc_pkg::cfg_t lowest;
        spcc_pkg::cfg_t highest;
        lowest = '{11'd0, 11'd0, 12'h800, 12'h800, 12'h800, 12'h800, 12'h800, 6'd0};
        highest = '{11'h7FF, 11'h7FF, 12'h7FF, 12'h7FF, 12'h7FF, 12'h7FF, 12'h7FF, 6'd63};
        plan = spcc_pkg::CFG_RESET;
        sim_minute = 0;
        sunny = 1'b0;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed ticks at the reset thresholds
        push_tick(0, 0, 0, 0, 0, 0, 0, 0);
        push_tick(-2048, 1, 2047, 1, -2048, 1, 0, 0);
        push_tick(2047, 1, -2048, 1, 2047, 1, 1, 63);
        push_tick(320, 1, 0, 1, 2047, 1, 1, 60);
        push_tick(1801, 1, 0, 1, 740, 1, 1, 61);
        push_tick(1800, 0, 0, 1, 739, 1, 1, 62);
        push_tick(1001, 1, 1800, 0, 761, 0, 1, 10);
        push_tick(0, 0, 0, 0, 761, 1, 1, 13);
        push_tick(0, 0, 0, 0, 0, 0, 1, 14);
        push_tick(0, 0, 0, 0, 0, 0, 1, 16);
        push_tick(0, 0, 0, 0, 0, 0, 1, 17);
        push_tick(901, 1, 800, 1, 379, 1, 0, 20, 1'b1);
        // stop compare at its boundary, minute past the hour clamps to 59
        push_tick(900, 1, 800, 1, 400, 1, 1, 63);
        push_tick(0, 0, 0, 0, 401, 1, 1, 4);
        push_tick(0, 0, 0, 0, 401, 1, 1, 5);
        push_tick(50, 1, -250, 1, 380, 1, 1, 30);
        push_tick(51, 1, -250, 1, 0, 1, 1, 30);
        push_tick(0, 0, 0, 0, 0, 0, 0, 31);
        push_tick(1000, 1, 1800, 1, 500, 1, 1, 40);
        push_tick(319, 1, -251, 1, 500, 1, 1, 41);
        push_tick(1500, 1, 321, 1, 500, 1, 1, 45);
        push_tick(0, 0, 0, 0, 500, 1, 1, 49);
        push_tick(0, 0, 0, 0, 500, 1, 0, 50);
        wait_until_idle();

        run_random(300);
        program_setting(lowest);
        run_random(150);
        program_setting(highest);
        run_random(150);
        repeat (4)
        begin
            program_setting(random_setting());
            run_random(200);
        end
        program_setting(spcc_pkg::CFG_RESET);
        no_idle = 1'b1;
        run_random(250);

        repeat (4) @(posedge clk);
        if (mismatches == 0 && expected_drives.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
